FILE: sv/lpp_pkg.sv
// Package for the LED pattern and PWM controller.
// Holds command and pattern codes, timing constants and the request,
// result and per-LED step types. No dependencies.
package lpp_pkg;

  localparam int LED_COUNT_DEF      = 5;
  localparam int PRIORITY_SLOTS_DEF = 4;
  localparam int PIN_W              = 5;

  localparam logic [2:0] CMD_FAST     = 3'd0;
  localparam logic [2:0] CMD_SLOW     = 3'd1;
  localparam logic [2:0] CMD_SET_PAT  = 3'd2;
  localparam logic [2:0] CMD_SET_DUTY = 3'd3;
  localparam logic [2:0] CMD_DEBUG    = 3'd4;

  localparam logic [2:0] PAT_NONE    = 3'd0;
  localparam logic [2:0] PAT_ONCE    = 3'd1;
  localparam logic [2:0] PAT_FLICK   = 3'd2;
  localparam logic [2:0] PAT_BREATHE = 3'd3;
  localparam logic [2:0] PAT_ON      = 3'd4;
  localparam logic [2:0] PAT_OFF     = 3'd5;

  localparam logic [3:0] PWM_TOP         = 4'd10;
  localparam logic [6:0] ONCE_LEN        = 7'd10;
  localparam logic [6:0] FLICK_LEN       = 7'd10;
  localparam logic [6:0] RAMP_TOP        = 7'd10;
  localparam logic [6:0] RAMP_DOWN_START = 7'd20;
  localparam logic [6:0] RAMP_DOWN_END   = 7'd30;
  localparam logic [6:0] BREATHE_PERIOD  = 7'd80;
  localparam logic [2:0] CHASE_DIV       = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] led_number;
    logic [2:0] priority_req;
    logic [2:0] pattern;
    logic [3:0] duty_value;
    logic       debug_on;
  } in_item_t;

  typedef struct packed {
    logic [4:0] led_pins;
    logic       debug_active;
  } out_item_t;

  typedef struct packed {
    logic       pin_we;
    logic       pin_val;
    logic [3:0] count;
    logic       hit;
    logic       duty_we;
    logic [3:0] duty_val;
    logic [6:0] timer;
    logic       slot_clr;
    logic [2:0] slot_idx;
  } led_res_t;

endpackage

FILE: sv/lpp_led_unit.sv
// Shared per-LED step unit: PWM advance on a fast tick, pattern service
// on a slow tick. Used once per cycle by the sequencer; depends on lpp_pkg.
module lpp_led_unit #(
  parameter int PRIORITY_SLOTS = lpp_pkg::PRIORITY_SLOTS_DEF
) (
  input  logic                           slow_tick,
  input  logic [PRIORITY_SLOTS-1:0][2:0] slot_row,
  input  logic [6:0]                     timer,
  input  logic [3:0]                     duty,
  input  logic [3:0]                     count,
  output lpp_pkg::led_res_t              res
);

  logic       found;
  logic [2:0] sel_idx;
  logic [2:0] sel_pat;
  logic [6:0] t_inc;

  always_comb begin
    found   = 1'b0;
    sel_idx = '0;
    sel_pat = lpp_pkg::PAT_NONE;
    for (int s = 0; s < PRIORITY_SLOTS; s++) begin
      if (slot_row[s] != lpp_pkg::PAT_NONE) begin
        found   = 1'b1;
        sel_idx = 3'(s);
        sel_pat = slot_row[s];
      end
    end
  end

  assign t_inc = timer + 7'd1;

  always_comb begin
    res          = '0;
    res.count    = count;
    res.timer    = timer;
    res.slot_idx = sel_idx;
    if (!slow_tick) begin
      if (count < duty) begin
        res.pin_we  = 1'b1;
        res.pin_val = 1'b1;
        res.count   = count + 4'd1;
      end else if (count < lpp_pkg::PWM_TOP) begin
        res.pin_we  = 1'b1;
        res.pin_val = 1'b0;
        res.count   = count + 4'd1;
      end else begin
        res.count = '0;
      end
    end else if (found) begin
      res.hit = 1'b1;
      case (sel_pat)
        lpp_pkg::PAT_ONCE: begin
          res.duty_we = 1'b1;
          if (t_inc < lpp_pkg::ONCE_LEN) begin
            res.timer    = t_inc;
            res.duty_val = lpp_pkg::PWM_TOP;
          end else begin
            res.timer    = '0;
            res.duty_val = '0;
            res.slot_clr = 1'b1;
          end
        end
        lpp_pkg::PAT_FLICK: begin
          res.timer = t_inc;
          if (t_inc == 7'd1) begin
            res.duty_we  = 1'b1;
            res.duty_val = lpp_pkg::PWM_TOP;
          end else if (t_inc == 7'd2) begin
            res.duty_we  = 1'b1;
            res.duty_val = '0;
          end else if (t_inc >= lpp_pkg::FLICK_LEN) begin
            res.timer = '0;
          end
        end
        lpp_pkg::PAT_BREATHE: begin
          res.timer = t_inc;
          if (t_inc <= lpp_pkg::RAMP_TOP) begin
            res.duty_we  = 1'b1;
            res.duty_val = t_inc[3:0];
          end else if (t_inc > lpp_pkg::RAMP_DOWN_START &&
                       t_inc <= lpp_pkg::RAMP_DOWN_END) begin
            res.duty_we  = 1'b1;
            res.duty_val = 4'(lpp_pkg::RAMP_DOWN_END - t_inc);
          end else if (t_inc >= lpp_pkg::BREATHE_PERIOD) begin
            res.timer = '0;
          end
        end
        lpp_pkg::PAT_ON: begin
          res.duty_we  = 1'b1;
          res.duty_val = lpp_pkg::PWM_TOP;
        end
        lpp_pkg::PAT_OFF: begin
          res.duty_we  = 1'b1;
          res.duty_val = '0;
        end
        default: begin
          res.timer = '0;
        end
      endcase
    end
  end

endmodule

FILE: sv/led_pattern_pwm_controller.sv
// Top level of the LED pattern and PWM controller: request handshake,
// LED walk sequencer, state storage, debug chase and result register.
// Depends on lpp_pkg and lpp_led_unit.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | lpp_pkg::in_item_t
//   out_    | out | out_valid/out_stall| lpp_pkg::out_item_t
//
// Fast and slow ticks outside debug walk the LEDs one per cycle through the
// shared step unit in ST_EXEC; other requests pass ST_EXEC without a walk.
// Every request then waits in ST_DONE until the output register can load.
// A new request is accepted once the sequencer is idle, even while a
// result waits in the output register under out_stall.
// Synchronous active-low reset clears all LED state, slots and timers.
module led_pattern_pwm_controller #(
  parameter int LED_COUNT      = lpp_pkg::LED_COUNT_DEF,
  parameter int PRIORITY_SLOTS = lpp_pkg::PRIORITY_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpp_pkg::out_item_t  out_data
);

  localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int SLOT_W = (PRIORITY_SLOTS > 1) ? $clog2(PRIORITY_SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               state_r, state_nxt;
  lpp_pkg::in_item_t        req_r;
  logic [LED_W-1:0]         led_idx_r, led_idx_nxt;
  logic [lpp_pkg::PIN_W-1:0] pin_r, pin_nxt;
  logic                     debug_r, debug_nxt;
  logic [2:0]               presc_r, presc_nxt;
  logic [3:0]               step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  lpp_pkg::out_item_t       out_data_r;

  logic [3:0]                     duty_r  [LED_COUNT];
  logic [3:0]                     cnt_r   [LED_COUNT];
  logic [6:0]                     timer_r [LED_COUNT];
  logic [PRIORITY_SLOTS-1:0][2:0] slots_r [LED_COUNT];

  logic                           in_acc, exec, walk, is_slow, last_led;
  logic [2:0]                     wr_num;
  logic [LED_W-1:0]               wr_led, rd_led;
  logic                           num_ok, prio_ok, pat_we, duty_we_cmd, out_load;
  logic [SLOT_W-1:0]              prio_idx;
  logic [PRIORITY_SLOTS-1:0][2:0] row;
  logic [2:0]                     chase_led;
  lpp_pkg::led_res_t              res;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign exec     = (state_r == ST_EXEC);
  assign is_slow  = (req_r.mode == lpp_pkg::CMD_SLOW);
  assign walk     = (req_r.mode == lpp_pkg::CMD_FAST || is_slow) && !debug_r;
  assign last_led = (led_idx_r == LED_W'(LED_COUNT - 1));

  assign wr_num   = req_r.led_number - 3'd1;
  assign wr_led   = wr_num[LED_W-1:0];
  assign num_ok   = (req_r.led_number != 3'd0) && (req_r.led_number <= 3'(LED_COUNT));
  assign prio_ok  = ({1'b0, req_r.priority_req} < 4'(PRIORITY_SLOTS));
  assign prio_idx = req_r.priority_req[SLOT_W-1:0];
  assign rd_led   = (req_r.mode == lpp_pkg::CMD_SET_PAT) ? (num_ok ? wr_led : '0)
                                                         : led_idx_r;
  assign row      = slots_r[rd_led];

  assign pat_we = exec && (req_r.mode == lpp_pkg::CMD_SET_PAT) && num_ok && prio_ok &&
                  (row[prio_idx] != req_r.pattern);
  assign duty_we_cmd = exec && (req_r.mode == lpp_pkg::CMD_SET_DUTY) && num_ok &&
                       (req_r.duty_value <= lpp_pkg::PWM_TOP);

  assign chase_led = step_r[3:1];

  lpp_led_unit #(
    .PRIORITY_SLOTS(PRIORITY_SLOTS)
  ) u_led_unit (
    .slow_tick(is_slow),
    .slot_row (row),
    .timer    (timer_r[led_idx_r]),
    .duty     (duty_r[led_idx_r]),
    .count    (cnt_r[led_idx_r]),
    .res      (res)
  );

  always_comb begin
    pin_nxt   = pin_r;
    debug_nxt = debug_r;
    presc_nxt = presc_r;
    step_nxt  = step_r;
    if (exec) begin
      if (walk) begin
        if (!is_slow && res.pin_we) begin
          pin_nxt[led_idx_r] = res.pin_val;
        end
      end else if (is_slow) begin
        presc_nxt = presc_r + 3'd1;
        if (presc_nxt >= lpp_pkg::CHASE_DIV) begin
          presc_nxt = '0;
          if ({1'b0, chase_led} >= 4'(LED_COUNT)) begin
            step_nxt = '0;
          end else if (!step_r[0]) begin
            pin_nxt[chase_led] = 1'b1;
            step_nxt           = step_r + 4'd1;
          end else begin
            pin_nxt[chase_led] = 1'b0;
            if ({1'b0, chase_led} + 4'd1 < 4'(LED_COUNT)) begin
              pin_nxt[chase_led + 3'd1] = 1'b1;
              step_nxt                  = step_r + 4'd2;
            end else begin
              step_nxt = '0;
            end
          end
        end
      end else if (req_r.mode == lpp_pkg::CMD_DEBUG) begin
        debug_nxt = req_r.debug_on;
        if (!req_r.debug_on) begin
          pin_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    led_idx_nxt = led_idx_r;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (walk && !last_led) begin
          led_idx_nxt = led_idx_r + LED_W'(1);
        end else begin
          led_idx_nxt = '0;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        led_idx_nxt = '0;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      led_idx_r   <= '0;
      pin_r       <= '0;
      debug_r     <= 1'b0;
      presc_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      led_idx_r   <= led_idx_nxt;
      pin_r       <= pin_nxt;
      debug_r     <= debug_nxt;
      presc_r     <= presc_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_data_r.led_pins     <= pin_r;
      out_data_r.debug_active <= debug_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LED_COUNT; k++) begin
      if (!rst_n) begin
        duty_r[k]  <= '0;
        cnt_r[k]   <= '0;
        timer_r[k] <= '0;
        slots_r[k] <= '0;
      end else begin
        if (exec && walk && led_idx_r == LED_W'(k)) begin
          if (!is_slow) begin
            cnt_r[k] <= res.count;
          end else if (res.hit) begin
            timer_r[k] <= res.timer;
            if (res.duty_we) begin
              duty_r[k] <= res.duty_val;
            end
            if (res.slot_clr) begin
              slots_r[k][res.slot_idx[SLOT_W-1:0]] <= lpp_pkg::PAT_NONE;
            end
          end
        end
        if (pat_we && wr_led == LED_W'(k)) begin
          slots_r[k][prio_idx] <= req_r.pattern;
          timer_r[k]           <= '0;
        end
        if (duty_we_cmd && wr_led == LED_W'(k)) begin
          duty_r[k] <= req_r.duty_value;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_EXEC)
    else $error("accepted request did not start execution");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  a_walk_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_EXEC |-> led_idx_r == '0)
    else $error("LED walk index left nonzero outside execution");

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && walk) |-> !(pat_we || duty_we_cmd))
    else $error("command write overlaps LED walk");

endmodule

FILE: sim/led_pattern_pwm_controller_tb.sv
// Self-checking testbench for led_pattern_pwm_controller: directed and random
// requests, a cycle-free predictor of the LED state and a result checker.
// Depends on lpp_pkg and the controller RTL.
`timescale 1ns / 100ps

module led_pattern_pwm_controller_tb;

  localparam int NLED = lpp_pkg::LED_COUNT_DEF;
  localparam int NSLOT = lpp_pkg::PRIORITY_SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = NLED + 6;

  localparam logic [2:0] CMD_NOP_FIRST = 3'd5;
  localparam logic [2:0] CMD_NOP_LAST = 3'd7;
  localparam logic [2:0] PAT_TIMER_CLR = 3'd6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lpp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lpp_pkg::out_item_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int failures = 0;
  int idle_cycles = 0;

  lpp_pkg::out_item_t due_led_states[$];

  logic [4:0] lit_mask = '0;
  logic [3:0] duty_lvl[NLED] = '{default: '0};
  logic [3:0] pwm_phase[NLED] = '{default: '0};
  logic [2:0] slot_pat[NLED][NSLOT] = '{default: '{default: lpp_pkg::PAT_NONE}};
  logic [6:0] pat_age[NLED] = '{default: '0};
  logic chase_on = 1'b0;
  logic [2:0] chase_div_cnt = '0;
  logic [3:0] chase_pos = '0;

  led_pattern_pwm_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic lpp_pkg::out_item_t next_led_state(lpp_pkg::in_item_t req);
    lpp_pkg::out_item_t res;
    int sel;
    int led;
    logic [6:0] age;
    logic [3:0] pos;
    led = int'(req.led_number) - 1;
    case (req.mode)
      lpp_pkg::CMD_FAST: begin
        if (!chase_on) begin
          for (int k = 0; k < NLED; k++) begin
            if (pwm_phase[k] < duty_lvl[k]) begin
              lit_mask[k] = 1'b1;
              pwm_phase[k] = pwm_phase[k] + 4'd1;
            end else if (pwm_phase[k] < lpp_pkg::PWM_TOP) begin
              lit_mask[k] = 1'b0;
              pwm_phase[k] = pwm_phase[k] + 4'd1;
            end else begin
              pwm_phase[k] = '0;
            end
          end
        end
      end
      lpp_pkg::CMD_SLOW: begin
        if (chase_on) begin
          chase_div_cnt = chase_div_cnt + 3'd1;
          if (chase_div_cnt >= lpp_pkg::CHASE_DIV) begin
            chase_div_cnt = '0;
            pos = chase_pos;
            sel = int'(pos >> 1);
            if (sel >= NLED) begin
              chase_pos = '0;
            end else if (!pos[0]) begin
              lit_mask[sel] = 1'b1;
              chase_pos = pos + 4'd1;
            end else begin
              lit_mask[sel] = 1'b0;
              if (sel + 1 < NLED) begin
                lit_mask[sel + 1] = 1'b1;
                chase_pos = pos + 4'd2;
              end else begin
                chase_pos = '0;
              end
            end
          end
        end else begin
          for (int k = 0; k < NLED; k++) begin
            sel = -1;
            for (int s = NSLOT - 1; s >= 0 && sel < 0; s--)
              if (slot_pat[k][s] != lpp_pkg::PAT_NONE) sel = s;
            if (sel >= 0) begin
              age = pat_age[k] + 7'd1;
              case (slot_pat[k][sel])
                lpp_pkg::PAT_ONCE: begin
                  if (age < lpp_pkg::ONCE_LEN) begin
                    pat_age[k] = age;
                    duty_lvl[k] = lpp_pkg::PWM_TOP;
                  end else begin
                    duty_lvl[k] = '0;
                    slot_pat[k][sel] = lpp_pkg::PAT_NONE;
                    pat_age[k] = '0;
                  end
                end
                lpp_pkg::PAT_FLICK: begin
                  pat_age[k] = age;
                  if (age == 7'd1) duty_lvl[k] = lpp_pkg::PWM_TOP;
                  else if (age == 7'd2) duty_lvl[k] = '0;
                  else if (age >= lpp_pkg::FLICK_LEN) pat_age[k] = '0;
                end
                lpp_pkg::PAT_BREATHE: begin
                  pat_age[k] = age;
                  if (age <= lpp_pkg::RAMP_TOP) duty_lvl[k] = age[3:0];
                  else if (age > lpp_pkg::RAMP_DOWN_START && age <= lpp_pkg::RAMP_DOWN_END)
                    duty_lvl[k] = 4'(lpp_pkg::RAMP_DOWN_END - age);
                  else if (age >= lpp_pkg::BREATHE_PERIOD) pat_age[k] = '0;
                end
                lpp_pkg::PAT_ON:  duty_lvl[k] = lpp_pkg::PWM_TOP;
                lpp_pkg::PAT_OFF: duty_lvl[k] = '0;
                default: pat_age[k] = '0;
              endcase
            end
          end
        end
      end
      lpp_pkg::CMD_SET_PAT: begin
        if (led >= 0 && led < NLED && int'(req.priority_req) < NSLOT &&
            slot_pat[led][req.priority_req] != req.pattern) begin
          slot_pat[led][req.priority_req] = req.pattern;
          pat_age[led] = '0;
        end
      end
      lpp_pkg::CMD_SET_DUTY: begin
        if (led >= 0 && led < NLED && req.duty_value <= lpp_pkg::PWM_TOP)
          duty_lvl[led] = req.duty_value;
      end
      lpp_pkg::CMD_DEBUG: begin
        if (req.debug_on) begin
          chase_on = 1'b1;
        end else begin
          chase_on = 1'b0;
          lit_mask = '0;
        end
      end
      default: ;
    endcase
    res.led_pins = lit_mask;
    res.debug_active = chase_on;
    return res;
  endfunction

  function automatic lpp_pkg::in_item_t make_req(logic [2:0] mode, logic [2:0] led,
                                                 logic [2:0] prio, logic [2:0] pat,
                                                 logic [3:0] duty, logic dbg);
    lpp_pkg::in_item_t req;
    req.mode = mode;
    req.led_number = led;
    req.priority_req = prio;
    req.pattern = pat;
    req.duty_value = duty;
    req.debug_on = dbg;
    return req;
  endfunction

  function automatic lpp_pkg::in_item_t random_item();
    lpp_pkg::in_item_t req;
    req = lpp_pkg::in_item_t'($urandom);
    return req;
  endfunction

  task automatic send_request(input lpp_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    due_led_states.push_back(next_led_state(req));
    requests_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [4:0] want,
                                 input logic [4:0] got);
    failures++;
    if (failures <= 10)
      $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic test_directed();
    send_request(make_req(lpp_pkg::CMD_FAST, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_DUTY, 3'd1, 3'd0, lpp_pkg::PAT_NONE,
                          lpp_pkg::PWM_TOP, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_DUTY, 3'd5, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_DUTY, 3'd3, 3'd0, lpp_pkg::PAT_NONE, 4'd15, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_DUTY, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd5, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_DUTY, 3'd7, 3'd0, lpp_pkg::PAT_NONE, 4'd5, 1'b0));
    send_request(make_req(lpp_pkg::CMD_FAST, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd1, 3'd3, lpp_pkg::PAT_ONCE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd1, 3'd3, lpp_pkg::PAT_ONCE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd2, 3'd4, lpp_pkg::PAT_ON, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd6, 3'd0, lpp_pkg::PAT_ON, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd3, 3'd0, lpp_pkg::PAT_FLICK, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd4, 3'd1, lpp_pkg::PAT_BREATHE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd5, 3'd2, lpp_pkg::PAT_OFF, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd2, 3'd0, PAT_TIMER_CLR, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SET_PAT, 3'd2, 3'd1, lpp_pkg::PAT_ON, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SLOW, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_SLOW, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_FAST, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_DEBUG, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b1));
    send_request(make_req(lpp_pkg::CMD_SLOW, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    send_request(make_req(lpp_pkg::CMD_DEBUG, 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
    for (logic [3:0] m = {1'b0, CMD_NOP_FIRST}; m <= {1'b0, CMD_NOP_LAST}; m++)
      send_request(make_req(m[2:0], 3'd0, 3'd0, lpp_pkg::PAT_NONE, 4'd0, 1'b0));
  endtask

  task automatic test_pwm(input int count);
    lpp_pkg::in_item_t req;
    int pick;
    for (int i = 0; i < count; i++) begin
      req = random_item();
      pick = $urandom_range(99);
      if (pick < 70) begin
        req.mode = lpp_pkg::CMD_FAST;
      end else if (pick < 85) begin
        req.mode = lpp_pkg::CMD_SET_DUTY;
        req.led_number = 3'($urandom_range(NLED, 1));
        req.duty_value = 4'($urandom_range(lpp_pkg::PWM_TOP));
      end else if (pick < 95) begin
        req.mode = lpp_pkg::CMD_SET_DUTY;
      end else if (req.mode == lpp_pkg::CMD_DEBUG) begin
        req.debug_on = 1'b0;
      end
      send_request(req);
    end
  endtask

  task automatic test_patterns(input int count);
    lpp_pkg::in_item_t req;
    int pick;
    req = random_item();
    req.mode = lpp_pkg::CMD_DEBUG;
    req.debug_on = 1'b0;
    send_request(req);
    for (int i = 0; i < count; i++) begin
      req = random_item();
      pick = $urandom_range(99);
      if (pick < 45) begin
        req.mode = lpp_pkg::CMD_SLOW;
      end else if (pick < 75) begin
        req.mode = lpp_pkg::CMD_FAST;
      end else if (pick < 88) begin
        req.mode = lpp_pkg::CMD_SET_PAT;
        req.led_number = 3'($urandom_range(NLED, 1));
        req.priority_req = 3'($urandom_range(NSLOT - 1));
      end else if (pick < 93) begin
        req.mode = lpp_pkg::CMD_SET_DUTY;
        req.led_number = 3'($urandom_range(NLED, 1));
        req.duty_value = 4'($urandom_range(lpp_pkg::PWM_TOP));
      end else if (req.mode == lpp_pkg::CMD_DEBUG) begin
        req.debug_on = 1'b0;
      end
      send_request(req);
    end
  endtask

  task automatic test_pattern_run(input int count);
    lpp_pkg::in_item_t req;
    for (int k = 1; k <= NLED; k++) begin
      req = random_item();
      req.mode = lpp_pkg::CMD_SET_PAT;
      req.led_number = 3'(k);
      req.priority_req = 3'($urandom_range(NSLOT - 1));
      req.pattern = ($urandom_range(1) != 0) ? lpp_pkg::PAT_BREATHE
                                             : 3'($urandom_range(7, 1));
      send_request(req);
    end
    for (int i = 0; i < count; i++) begin
      req = random_item();
      req.mode = ($urandom_range(99) < 60) ? lpp_pkg::CMD_SLOW : lpp_pkg::CMD_FAST;
      send_request(req);
    end
  endtask

  task automatic test_debug_chase(input int count);
    lpp_pkg::in_item_t req;
    int pick;
    req = random_item();
    req.mode = lpp_pkg::CMD_DEBUG;
    req.debug_on = 1'b1;
    send_request(req);
    for (int i = 0; i < count; i++) begin
      req = random_item();
      pick = $urandom_range(99);
      if (pick < 75) begin
        req.mode = lpp_pkg::CMD_SLOW;
      end else if (pick < 85) begin
        req.mode = lpp_pkg::CMD_FAST;
      end else if (pick < 95) begin
        req.mode = ($urandom_range(1) != 0) ? lpp_pkg::CMD_SET_PAT : lpp_pkg::CMD_SET_DUTY;
        req.led_number = 3'($urandom_range(NLED, 1));
        req.priority_req = 3'($urandom_range(NSLOT - 1));
        req.duty_value = 4'($urandom_range(lpp_pkg::PWM_TOP));
      end else begin
        req.mode = lpp_pkg::CMD_DEBUG;
        req.debug_on = 1'b1;
      end
      send_request(req);
    end
    req = random_item();
    req.mode = lpp_pkg::CMD_DEBUG;
    req.debug_on = 1'b0;
    send_request(req);
  endtask

  task automatic test_noise(input int count);
    for (int i = 0; i < count; i++)
      send_request(random_item());
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    lpp_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_led_states.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data.led_pins);
      end else begin
        want = due_led_states.pop_front();
        results_checked++;
        if (out_data.led_pins !== want.led_pins)
          report_mismatch("led_pins", want.led_pins, out_data.led_pins);
        if (out_data.debug_active !== want.debug_active)
          report_mismatch("debug_active", 5'(want.debug_active), 5'(out_data.debug_active));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a handshake", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 54;
    test_directed();
    test_pwm(60);
    test_patterns(70);

    send_idle_pct = 54;
    recv_idle_pct = 7;
    test_pattern_run(95);
    test_debug_chase(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_patterns(50);
    test_pwm(30);
    test_noise(50);

    in_valid <= 1'b0;
    while (due_led_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: PWM ticks, pattern slots, breathe/once/flick timing,",
             requests_sent);
    $display("debug chase and ignored writes; %0d results checked, %0d failures.",
             results_checked, failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
